@@ rtl/cgti_pkg.sv @@
// Shared types, constants and tetrahedron tables for the cube grid indexer.
package cgti_pkg;

   localparam int MAX_CELLS = 1024;
   localparam int IDX_W = 31;
   localparam int CELL_W = 11;
   localparam int PROD_W = 21;
   localparam int BND_W = 16;
   localparam int CODE_W = 8;
   localparam int PACK_W = 64;
   localparam int CSR_IDX_W = 3;
   localparam logic [CODE_W-1:0] PERIODIC_CODE = 8'd6;
   localparam int NUM_TETS = 6;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOUND_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BOUND_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BOUND_Z = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDE_PACK = 3'd6;

   // Corner offsets of each tetrahedron: bit 0 x, bit 1 y, bit 2 z
   localparam logic [2:0] TET_CORNER [NUM_TETS][4] = '{
      '{3'd0, 3'd1, 3'd2, 3'd6},
      '{3'd0, 3'd1, 3'd6, 3'd4},
      '{3'd1, 3'd6, 3'd4, 3'd5},
      '{3'd7, 3'd6, 3'd5, 3'd1},
      '{3'd7, 3'd6, 3'd1, 3'd3},
      '{3'd6, 3'd1, 3'd3, 3'd2}
   };

   // Corner left out by each face
   localparam logic [1:0] FACE_OMIT [4] = '{2'd3, 2'd2, 2'd0, 2'd1};

   typedef struct packed {
      logic             mode;
      logic [IDX_W-1:0] item_index;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]  corner_a;
      logic [IDX_W-1:0]  corner_b;
      logic [IDX_W-1:0]  corner_c;
      logic [IDX_W-1:0]  corner_d;
      logic [CODE_W-1:0] face_code_0;
      logic [CODE_W-1:0] face_code_1;
      logic [CODE_W-1:0] face_code_2;
      logic [CODE_W-1:0] face_code_3;
      logic [PACK_W-1:0] packed_codes;
      logic [IDX_W-1:0]  partner_vertex;
      logic              last_of_run;
   } rsp_type;

   // Effective configuration seen by the datapath
   typedef struct packed {
      logic [CELL_W-1:0] n_x;
      logic [CELL_W-1:0] n_y;
      logic [CELL_W-1:0] n_z;
      logic [CELL_W-1:0] p_x;
      logic [CELL_W-1:0] p_y;
      logic [BND_W-1:0]  bnd_x;
      logic [BND_W-1:0]  bnd_y;
      logic [BND_W-1:0]  bnd_z;
      logic              wide;
   } cfg_type;

   // One decoded item waiting for the back end
   typedef struct packed {
      logic              mode;
      logic [CELL_W-1:0] c_x;
      logic [CELL_W-1:0] c_y;
      logic [IDX_W-1:0]  c_z;
      logic [IDX_W-1:0]  base;
   } entry_type;

   function automatic logic [CELL_W-1:0] eff_cells(input logic [CELL_W-1:0] c);
      logic [CELL_W-1:0] r;
      r = c;
      if (c == '0) r = CELL_W'(1);
      else if (c > CELL_W'(MAX_CELLS)) r = CELL_W'(MAX_CELLS);
      return r;
   endfunction

   function automatic logic periodic(input logic [BND_W-1:0] b);
      return (b[7:0] == PERIODIC_CODE) && (b[15:8] == PERIODIC_CODE);
   endfunction

   // Face j of tetrahedron t: {lies in an axis plane, plane offset}
   function automatic logic [1:0] face_axis(input logic [2:0] t, input logic [1:0] j,
                                            input int a);
      logic seen;
      logic fst;
      logic same;
      logic bitv;
      seen = 1'b0;
      fst = 1'b0;
      same = 1'b1;
      for (int k = 0; k < 4; k++) begin
         if (2'(k) != FACE_OMIT[j]) begin
            bitv = TET_CORNER[t][k][a];
            if (!seen) begin
               fst = bitv;
               seen = 1'b1;
            end else if (bitv != fst) begin
               same = 1'b0;
            end
         end
      end
      return {same, fst};
   endfunction

endpackage

@@ rtl/cgti_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module cgti_div_pipe #(
   parameter int NUM_W  = 31,
   parameter int DEN_W  = 21,
   parameter int QUO_W  = 31,
   parameter int SIDE_W = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quo,
   output logic [NUM_W-1:0]  out_rem,
   output logic [DEN_W-1:0]  out_den,
   output logic [SIDE_W-1:0] out_side
);

   localparam int W = NUM_W + DEN_W + QUO_W;

   logic              valid_ff [1:QUO_W];
   logic [NUM_W-1:0]  rem_ff   [1:QUO_W];
   logic [QUO_W-1:0]  quo_ff   [1:QUO_W];
   logic [DEN_W-1:0]  den_ff   [1:QUO_W];
   logic [SIDE_W-1:0] side_ff  [1:QUO_W];

   for (genvar i = 0; i < QUO_W; i++) begin : g_stage
      localparam int B = QUO_W - 1 - i;
      logic              src_valid;
      logic [NUM_W-1:0]  src_rem;
      logic [QUO_W-1:0]  src_quo;
      logic [DEN_W-1:0]  src_den;
      logic [SIDE_W-1:0] src_side;
      logic [W-1:0]      shifted;
      logic [NUM_W-1:0]  rem_in;
      logic [QUO_W-1:0]  quo_in;

      if (i == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_rem   = in_num;
         assign src_quo   = '0;
         assign src_den   = in_den;
         assign src_side  = in_side;
      end else begin : g_next
         assign src_valid = valid_ff[i];
         assign src_rem   = rem_ff[i];
         assign src_quo   = quo_ff[i];
         assign src_den   = den_ff[i];
         assign src_side  = side_ff[i];
      end

      // Try to subtract the divisor at this bit weight
      always_comb begin
         shifted = W'(src_den) << B;
         rem_in = src_rem;
         quo_in = src_quo;
         if (W'(src_rem) >= shifted) begin
            rem_in = src_rem - shifted[NUM_W-1:0];
            quo_in[B] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else begin
            valid_ff[i+1] <= src_valid;
         end
         rem_ff[i+1]  <= rem_in;
         quo_ff[i+1]  <= quo_in;
         den_ff[i+1]  <= src_den;
         side_ff[i+1] <= src_side;
      end
   end

   assign out_valid = valid_ff[QUO_W];
   assign out_quo   = quo_ff[QUO_W];
   assign out_rem   = rem_ff[QUO_W];
   assign out_den   = den_ff[QUO_W];
   assign out_side  = side_ff[QUO_W];

endmodule

@@ rtl/cgti_front.sv @@
// Front end: split the item index into grid coordinates and form the base vertex.
module cgti_front
   import cgti_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  req_type           req,
   input  cfg_type           cfg,
   input  logic [PROD_W-1:0] p01,
   output logic              entry_valid,
   output entry_type         entry
);

   logic              pre_valid_ff;
   logic              pre_mode_ff;
   logic [IDX_W-1:0]  pre_num_ff;
   logic [PROD_W-1:0] pre_d1_ff;
   logic [CELL_W-1:0] pre_d0_ff;
   logic [CELL_W-1:0] sel_x;
   logic [CELL_W-1:0] sel_y;

   // Pick cube or vertex counts and form the plane divisor
   assign sel_x = req.mode ? cfg.p_x : cfg.n_x;
   assign sel_y = req.mode ? cfg.p_y : cfg.n_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else begin
         pre_valid_ff <= accept;
      end
      pre_mode_ff <= req.mode;
      pre_num_ff  <= req.item_index;
      pre_d1_ff   <= PROD_W'(sel_x) * PROD_W'(sel_y);
      pre_d0_ff   <= sel_x;
   end

   logic              d1_valid;
   logic [IDX_W-1:0]  d1_quo;
   logic [IDX_W-1:0]  d1_rem;
   logic [PROD_W-1:0] d1_den;
   logic [CELL_W:0]   d1_side;

   // z = index / plane size
   cgti_div_pipe #(
      .NUM_W (IDX_W),
      .DEN_W (PROD_W),
      .QUO_W (IDX_W),
      .SIDE_W(CELL_W + 1)
   ) u_div_z (
      .clock    (clock),
      .reset    (reset),
      .in_valid (pre_valid_ff),
      .in_num   (pre_num_ff),
      .in_den   (pre_d1_ff),
      .in_side  ({pre_mode_ff, pre_d0_ff}),
      .out_valid(d1_valid),
      .out_quo  (d1_quo),
      .out_rem  (d1_rem),
      .out_den  (d1_den),
      .out_side (d1_side)
   );

   logic              d2_valid;
   logic [CELL_W-1:0] d2_quo;
   logic [PROD_W-1:0] d2_rem;
   logic [CELL_W-1:0] d2_den;
   logic [IDX_W:0]    d2_side;
   logic              unused_den;

   assign unused_den = ^d1_den ^ ^d2_den ^ ^d1_rem[IDX_W-1:PROD_W];

   // y = remainder / row size, x = what is left
   cgti_div_pipe #(
      .NUM_W (PROD_W),
      .DEN_W (CELL_W),
      .QUO_W (CELL_W),
      .SIDE_W(IDX_W + 1)
   ) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .in_valid (d1_valid),
      .in_num   (d1_rem[PROD_W-1:0]),
      .in_den   (d1_side[CELL_W-1:0]),
      .in_side  ({d1_side[CELL_W], d1_quo}),
      .out_valid(d2_valid),
      .out_quo  (d2_quo),
      .out_rem  (d2_rem),
      .out_den  (d2_den),
      .out_side (d2_side)
   );

   logic              mode_d2;
   logic [IDX_W-1:0]  cz_d2;
   logic [CELL_W-1:0] cx_d2;
   logic [CELL_W-1:0] cx_adj;
   logic [CELL_W-1:0] cy_adj;
   logic [IDX_W-1:0]  cz_adj;

   assign mode_d2 = d2_side[IDX_W];
   assign cz_d2   = d2_side[IDX_W-1:0];
   assign cx_d2   = d2_rem[CELL_W-1:0];

   // Fold the far plane of each periodic axis onto plane 0 (vertex mode)
   always_comb begin
      cx_adj = cx_d2;
      cy_adj = d2_quo;
      cz_adj = cz_d2;
      if (mode_d2) begin
         if (periodic(cfg.bnd_x) && cx_d2 == cfg.n_x) cx_adj = '0;
         if (periodic(cfg.bnd_y) && d2_quo == cfg.n_y) cy_adj = '0;
         if (periodic(cfg.bnd_z) && cz_d2 == IDX_W'(cfg.n_z)) cz_adj = '0;
      end
   end

   logic                mul_valid_ff;
   logic                mul_mode_ff;
   logic [CELL_W-1:0]   mul_cx_ff;
   logic [CELL_W-1:0]   mul_cy_ff;
   logic [IDX_W-1:0]    mul_cz_ff;
   logic [IDX_W-1:0]    mul_mz_ff;
   logic [2*CELL_W-1:0] mul_my_ff;
   logic [IDX_W+PROD_W-1:0] prod_z;

   assign prod_z = (IDX_W + PROD_W)'(p01) * (IDX_W + PROD_W)'(cz_adj);

   // Scale z and y by their strides
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= d2_valid;
      end
      mul_mode_ff <= mode_d2;
      mul_cx_ff   <= cx_adj;
      mul_cy_ff   <= cy_adj;
      mul_cz_ff   <= cz_adj;
      mul_mz_ff   <= prod_z[IDX_W-1:0];
      mul_my_ff   <= (2*CELL_W)'(cfg.p_x) * (2*CELL_W)'(cy_adj);
   end

   logic      entry_valid_ff;
   entry_type entry_ff;

   // Sum into the base vertex index
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else begin
         entry_valid_ff <= mul_valid_ff;
      end
      entry_ff.mode <= mul_mode_ff;
      entry_ff.c_x  <= mul_cx_ff;
      entry_ff.c_y  <= mul_cy_ff;
      entry_ff.c_z  <= mul_cz_ff;
      entry_ff.base <= mul_mz_ff + IDX_W'(mul_my_ff) + IDX_W'(mul_cx_ff);
   end

   assign entry_valid = entry_valid_ff;
   assign entry = entry_ff;

endmodule

@@ rtl/cgti_queue.sv @@
// Short queue of decoded items between the front and back ends.
module cgti_queue
   import cgti_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   input  logic      pop,
   output entry_type head,
   output logic      empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   // Advance pointers on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= bump(wr_ptr_ff);
         if (pop) rd_ptr_ff <= bump(rd_ptr_ff);
         count_ff <= count_ff + CNT_W'(push) - CNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   assign head  = mem_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);

endmodule

@@ rtl/cgti_back.sv @@
// Back end: walk the six tetrahedra of a cube, or emit the periodic partner.
module cgti_back
   import cgti_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic [PROD_W-1:0] p01,
   input  entry_type         head,
   input  logic              empty,
   output logic              pop,
   output logic              rsp_valid,
   output rsp_type           rsp
);

   logic      active_ff;
   logic [2:0] tet_ff;
   entry_type cur_ff;
   logic      last;

   assign last = cur_ff.mode || (tet_ff == 3'(NUM_TETS - 1));
   assign pop  = !empty && (!active_ff || last);

   // Load the next item as soon as the current one ends
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         tet_ff    <= '0;
      end else if (pop) begin
         active_ff <= 1'b1;
         tet_ff    <= '0;
      end else if (active_ff && last) begin
         active_ff <= 1'b0;
      end else if (active_ff) begin
         tet_ff <= tet_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) cur_ff <= head;
   end

   logic [IDX_W-1:0]  corner [4];
   logic [CODE_W-1:0] code [4];
   logic [PACK_W-1:0] packed_w;
   logic [IDX_W:0]    coord [3];
   logic [IDX_W:0]    limit [3];
   logic [BND_W-1:0]  bnd [3];
   logic [2:0]        off;
   logic [1:0]        fa;
   logic [IDX_W:0]    pos;
   rsp_type           rsp_in;

   // Form corners and face codes of the current tetrahedron
   always_comb begin
      coord[0] = (IDX_W + 1)'(cur_ff.c_x);
      coord[1] = (IDX_W + 1)'(cur_ff.c_y);
      coord[2] = (IDX_W + 1)'(cur_ff.c_z);
      limit[0] = (IDX_W + 1)'(cfg.n_x);
      limit[1] = (IDX_W + 1)'(cfg.n_y);
      limit[2] = (IDX_W + 1)'(cfg.n_z);
      bnd[0] = cfg.bnd_x;
      bnd[1] = cfg.bnd_y;
      bnd[2] = cfg.bnd_z;
      off = '0;
      fa = '0;
      pos = '0;
      for (int j = 0; j < 4; j++) begin
         off = TET_CORNER[tet_ff][j];
         corner[j] = cur_ff.base + (off[2] ? IDX_W'(p01) : '0)
                   + (off[1] ? IDX_W'(cfg.p_x) : '0) + IDX_W'(off[0]);
         code[j] = '0;
         for (int a = 0; a < 3; a++) begin
            fa = face_axis(tet_ff, 2'(j), a);
            if (fa[1]) begin
               pos = coord[a] + (IDX_W + 1)'(fa[0]);
               if (pos == '0) code[j] = bnd[a][7:0];
               else if (pos == limit[a]) code[j] = bnd[a][15:8];
               else code[j] = '0;
            end
         end
      end
      if (cfg.wide) begin
         packed_w = {8'd0, code[3], 8'd0, code[2], 8'd0, code[1], 8'd0, code[0]};
      end else begin
         packed_w = {32'd0, code[3], code[2], code[1], code[0]};
      end
      rsp_in = '0;
      rsp_in.last_of_run = last;
      if (cur_ff.mode) begin
         rsp_in.partner_vertex = cur_ff.base;
      end else begin
         rsp_in.corner_a = corner[0];
         rsp_in.corner_b = corner[1];
         rsp_in.corner_c = corner[2];
         rsp_in.corner_d = corner[3];
         rsp_in.face_code_0 = code[0];
         rsp_in.face_code_1 = code[1];
         rsp_in.face_code_2 = code[2];
         rsp_in.face_code_3 = code[3];
         rsp_in.packed_codes = packed_w;
      end
   end

   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   // Register the result strobe and payload
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= active_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

endmodule

@@ rtl/cube_grid_tetrahedra_indexer_core.sv @@
// Top level of the cube grid tetrahedra indexer: registers, credit count, front, queue, back.
//
// Usage: drive req_data and raise start; the item is taken at an edge where start is
// high and busy is low. In mode 0 the item is a linear cube index and yields six
// results, one per tetrahedron; in mode 1 it is a vertex index and yields one result
// with its periodic partner. Results appear on rsp_data for one cycle each, marked by
// rsp_valid; last_of_run flags the final result of an item. The receiver cannot stall.
// An accepted item passes the input registers, the two pipelined dividers
// (31 plus 11 stages), the multiply and sum registers, the queue and the output register.
// Throughput: while the queue holds items the back end sends one result per cycle, six
// per cube item and one per vertex item. The front end accepts one item per cycle while
// fewer than QDEPTH items are in flight between accept and the back end; busy is
// high when that credit count is full.
// Configuration: csr_we writes csr_wdata into register csr_index at once; write only
// while no item is outstanding. Reset clears all control state, sets the cell counts
// to 1, both boundary codes of each axis to 1 and selects 8-bit packing.
module cube_grid_tetrahedra_indexer_core
   import cgti_pkg::*;
#(
   parameter int QDEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BND_W-1:0]     csr_wdata
);

   localparam int CNT_W = $clog2(QDEPTH + 1);

   logic [CELL_W-1:0] cells_x_ff;
   logic [CELL_W-1:0] cells_y_ff;
   logic [CELL_W-1:0] cells_z_ff;
   logic [BND_W-1:0]  bound_x_ff;
   logic [BND_W-1:0]  bound_y_ff;
   logic [BND_W-1:0]  bound_z_ff;
   logic              wide_ff;

   // Take register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cells_x_ff <= CELL_W'(1);
         cells_y_ff <= CELL_W'(1);
         cells_z_ff <= CELL_W'(1);
         bound_x_ff <= BND_W'(257);
         bound_y_ff <= BND_W'(257);
         bound_z_ff <= BND_W'(257);
         wide_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CELLS_X:   cells_x_ff <= csr_wdata[CELL_W-1:0];
            CSR_CELLS_Y:   cells_y_ff <= csr_wdata[CELL_W-1:0];
            CSR_CELLS_Z:   cells_z_ff <= csr_wdata[CELL_W-1:0];
            CSR_BOUND_X:   bound_x_ff <= csr_wdata;
            CSR_BOUND_Y:   bound_y_ff <= csr_wdata;
            CSR_BOUND_Z:   bound_z_ff <= csr_wdata;
            CSR_WIDE_PACK: wide_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   cfg_type           cfg;
   logic [PROD_W-1:0] p01_ff;

   // Clamp cell counts and derive vertex counts
   always_comb begin
      cfg.n_x   = eff_cells(cells_x_ff);
      cfg.n_y   = eff_cells(cells_y_ff);
      cfg.n_z   = eff_cells(cells_z_ff);
      cfg.p_x   = cfg.n_x + CELL_W'(1);
      cfg.p_y   = cfg.n_y + CELL_W'(1);
      cfg.bnd_x = bound_x_ff;
      cfg.bnd_y = bound_y_ff;
      cfg.bnd_z = bound_z_ff;
      cfg.wide  = wide_ff;
   end

   // Hold the vertex plane size; items reach its users only after passing the dividers
   always_ff @(posedge clock) begin
      p01_ff <= PROD_W'(cfg.p_x) * PROD_W'(cfg.p_y);
   end

   logic             accept;
   logic             pop;
   logic [CNT_W-1:0] inflight_ff;

   assign busy   = (inflight_ff == CNT_W'(QDEPTH));
   assign accept = start && !busy;

   // Count items between accept and the back end
   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_ff + CNT_W'(accept) - CNT_W'(pop);
      end
   end

   logic      entry_valid;
   entry_type entry;
   entry_type head;
   logic      empty;

   cgti_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_data),
      .cfg        (cfg),
      .p01        (p01_ff),
      .entry_valid(entry_valid),
      .entry      (entry)
   );

   cgti_queue #(
      .DEPTH(QDEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (entry_valid),
      .push_data(entry),
      .pop      (pop),
      .head     (head),
      .empty    (empty)
   );

   cgti_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .p01      (p01_ff),
      .head     (head),
      .empty    (empty),
      .pop      (pop),
      .rsp_valid(rsp_valid),
      .rsp      (rsp_data)
   );

`ifndef SYNTHESIS
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= CNT_W'(QDEPTH))
      else $error("in-flight count exceeds queue depth");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_of_run |=> rsp_valid)
      else $error("tetrahedron run broken before its last result");

   a_partner_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.partner_vertex != '0
         |-> rsp_data.last_of_run && rsp_data.corner_a == '0)
      else $error("partner vertex seen on a tetrahedron result");

   a_pop_needs_credit: assert property (@(posedge clock) disable iff (reset)
      pop |-> inflight_ff != '0)
      else $error("queue read with no item in flight");
`endif

endmodule
